@@ src/ctl_pkg.sv @@
// shared types and constants for the closed tour length block
`timescale 1ns / 1ps
package ctl_pkg;

  // fixed field widths
  localparam int unsigned CITY_W  = 7;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned LEN_W   = 23;
  localparam int unsigned COUNT_W = 7;

  // defaults for the top level parameters
  localparam int unsigned MAX_CITIES_DEF = 64;
  localparam int unsigned COORD_BITS_DEF = 16;

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // command codes of the input beat
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TOUR  = 1'b1;

  typedef enum logic {
    OP_WRITE,
    OP_TOUR
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_DIFF,
    ST_SQR,
    ST_SUM,
    ST_ROOT,
    ST_ACC,
    ST_OUT
  } back_state_e;

  typedef struct packed {
    logic              command;
    logic [CITY_W-1:0] city;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic              last;
  } in_beat_t;

  typedef struct packed {
    logic [LEN_W-1:0]   tour_length;
    logic [COUNT_W-1:0] city_count;
  } out_beat_t;

  // one classified operation handed to the back end
  typedef struct packed {
    op_e               op;
    logic              city_ok;
    logic [CITY_W-1:0] city;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic              last;
  } op_t;

endpackage

@@ src/ctl_front.sv @@
// front end: takes input beats, checks the city and queues operations
`timescale 1ns / 1ps
module ctl_front #(
  parameter int unsigned MAX_CITIES = ctl_pkg::MAX_CITIES_DEF
) (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ctl_pkg::in_beat_t in_beat_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output ctl_pkg::op_t      q_data_o
);

  logic city_ok;
  logic keep;

  // city number must be one-based and inside the table
  assign city_ok = (in_beat_i.city != '0) &&
                   (32'(in_beat_i.city) <= 32'(MAX_CITIES));

  // drop writes to bad cities and bad tour cities that do not close
  always_comb begin
    if (in_beat_i.command == ctl_pkg::CMD_WRITE) begin
      keep = city_ok;
    end else begin
      keep = city_ok | in_beat_i.last;
    end
  end

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && keep;

  // classified operation
  always_comb begin
    q_data_o.op      = (in_beat_i.command == ctl_pkg::CMD_WRITE) ?
                       ctl_pkg::OP_WRITE : ctl_pkg::OP_TOUR;
    q_data_o.city_ok = city_ok;
    q_data_o.city    = in_beat_i.city;
    q_data_o.pos_x   = in_beat_i.pos_x;
    q_data_o.pos_y   = in_beat_i.pos_y;
    q_data_o.last    = in_beat_i.last;
  end

endmodule

@@ src/ctl_queue.sv @@
// small operation queue between front and back end
`timescale 1ns / 1ps
module ctl_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  ctl_pkg::op_t push_data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output ctl_pkg::op_t pop_data_o
);

  ctl_pkg::op_t                  slot_q [ctl_pkg::QUEUE_DEPTH];
  logic [ctl_pkg::QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [ctl_pkg::QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [ctl_pkg::QCNT_W-1:0]    cnt_q, cnt_d;
  logic                          do_push;
  logic                          do_pop;

  assign full_o     = (cnt_q == ctl_pkg::QCNT_W'(ctl_pkg::QUEUE_DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = slot_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == ctl_pkg::QPTR_W'(ctl_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == ctl_pkg::QPTR_W'(ctl_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ src/ctl_back.sv @@
// back end: position table, distance unit, square root and tour sum
`timescale 1ns / 1ps
module ctl_back #(
  parameter int unsigned MAX_CITIES = ctl_pkg::MAX_CITIES_DEF,
  parameter int unsigned COORD_BITS = ctl_pkg::COORD_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  ctl_pkg::op_t       q_data_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ctl_pkg::out_beat_t out_beat_o
);

  localparam int unsigned COORD_W = (COORD_BITS < ctl_pkg::POS_W) ?
                                    COORD_BITS : ctl_pkg::POS_W;
  localparam int unsigned IDX_W   = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
  localparam int unsigned CNT_W   = $clog2(MAX_CITIES + 1);
  localparam int unsigned ENT_W   = 2 * COORD_W;
  localparam int unsigned ROOT_W  = COORD_W + 1;
  localparam int unsigned RAD_W   = 2 * ROOT_W;
  localparam int unsigned REM_W   = ROOT_W + 2;
  localparam int unsigned ITER_W  = $clog2(ROOT_W + 1);
  localparam int unsigned LEN_W   = ctl_pkg::LEN_W;

  ctl_pkg::back_state_e state_q, state_d;

  // tour state
  logic [IDX_W-1:0] prev_q, prev_d;
  logic [LEN_W-1:0] sum_q, sum_d;
  logic             started_q, started_d;
  logic [CNT_W-1:0] count_q, count_d;

  // endpoints of the distance at work and what follows it
  logic [IDX_W-1:0] da_q, da_d;
  logic [IDX_W-1:0] db_q, db_d;
  logic             need_close_q, need_close_d;
  logic             emit_q, emit_d;

  // output register
  logic               out_valid_q, out_valid_d;
  ctl_pkg::out_beat_t out_q;
  logic               out_load;

  // position table
  logic [ENT_W-1:0] mem [MAX_CITIES];
  logic [ENT_W-1:0] rd_q;
  logic [ENT_W-1:0] pa_q;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic [IDX_W-1:0] op_idx;

  // distance datapath
  logic [COORD_W-1:0] ax, ay, bx, by;
  logic [COORD_W-1:0] dx_q, dy_q;
  logic [ENT_W-1:0]   sqx_q, sqy_q;
  logic [RAD_W-1:0]   rad_q;
  logic [REM_W-1:0]   rem_q;
  logic [ROOT_W-1:0]  root_q;
  logic [ITER_W-1:0]  iter_q;
  logic [REM_W-1:0]   rem_next;
  logic [REM_W-1:0]   trial;
  logic               root_bit;
  logic [LEN_W:0]     sum_wide;

  assign op_idx  = IDX_W'(q_data_i.city - ctl_pkg::CITY_W'(1));
  assign rd_addr = (state_q == ctl_pkg::ST_RD_A) ? da_q : db_q;
  assign mem_we  = (state_q == ctl_pkg::ST_IDLE) && q_valid_i &&
                   (q_data_i.op == ctl_pkg::OP_WRITE) && q_data_i.city_ok;

  // table write and registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[op_idx] <= {COORD_W'(q_data_i.pos_x), COORD_W'(q_data_i.pos_y)};
    end
    rd_q <= mem[rd_addr];
  end

  // one restoring square root step
  assign rem_next = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial    = {root_q, 2'b01};
  assign root_bit = (rem_next >= trial);
  assign sum_wide = (LEN_W + 1)'(sum_q) + (LEN_W + 1)'(root_q);

  assign ax = pa_q[ENT_W-1 -: COORD_W];
  assign ay = pa_q[COORD_W-1:0];
  assign bx = rd_q[ENT_W-1 -: COORD_W];
  assign by = rd_q[COORD_W-1:0];

  // distance datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ctl_pkg::ST_RD_B: begin
        pa_q <= rd_q;
      end
      ctl_pkg::ST_DIFF: begin
        dx_q <= (ax >= bx) ? ax - bx : bx - ax;
        dy_q <= (ay >= by) ? ay - by : by - ay;
      end
      ctl_pkg::ST_SQR: begin
        sqx_q <= ENT_W'(dx_q) * ENT_W'(dx_q);
        sqy_q <= ENT_W'(dy_q) * ENT_W'(dy_q);
      end
      ctl_pkg::ST_SUM: begin
        rad_q  <= RAD_W'(sqx_q) + RAD_W'(sqy_q);
        rem_q  <= '0;
        root_q <= '0;
        iter_q <= '0;
      end
      ctl_pkg::ST_ROOT: begin
        rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
        rem_q  <= root_bit ? rem_next - trial : rem_next;
        root_q <= {root_q[ROOT_W-2:0], root_bit};
        iter_q <= iter_q + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // state register and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ctl_pkg::ST_IDLE;
      prev_q       <= '0;
      sum_q        <= '0;
      started_q    <= 1'b0;
      count_q      <= '0;
      da_q         <= '0;
      db_q         <= '0;
      need_close_q <= 1'b0;
      emit_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      prev_q       <= prev_d;
      sum_q        <= sum_d;
      started_q    <= started_d;
      count_q      <= count_d;
      da_q         <= da_d;
      db_q         <= db_d;
      need_close_q <= need_close_d;
      emit_q       <= emit_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.tour_length <= sum_q;
      out_q.city_count  <= ctl_pkg::COUNT_W'(count_q);
    end
  end

  // sequencer: next state and tour bookkeeping
  always_comb begin
    state_d      = state_q;
    prev_d       = prev_q;
    sum_d        = sum_q;
    started_d    = started_q;
    count_d      = count_q;
    da_d         = da_q;
    db_d         = db_q;
    need_close_d = need_close_q;
    emit_d       = emit_q;
    q_pop_o      = 1'b0;
    out_load     = 1'b0;

    case (state_q)
      ctl_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_data_i.op == ctl_pkg::OP_TOUR) begin
            if (q_data_i.city_ok) begin
              prev_d    = op_idx;
              started_d = 1'b1;
              if (32'(count_q) < 32'(MAX_CITIES)) begin
                count_d = count_q + 1'b1;
              end
              if (started_q) begin
                // leg from the previous city, then maybe the closing leg
                da_d         = prev_q;
                db_d         = op_idx;
                need_close_d = q_data_i.last;
                emit_d       = q_data_i.last;
                state_d      = ctl_pkg::ST_RD_A;
              end else if (q_data_i.last) begin
                da_d         = op_idx;
                db_d         = '0;
                need_close_d = 1'b0;
                emit_d       = 1'b1;
                state_d      = ctl_pkg::ST_RD_A;
              end
            end else if (q_data_i.last) begin
              // bad city that still closes the tour
              if (started_q) begin
                da_d         = prev_q;
                db_d         = '0;
                need_close_d = 1'b0;
                emit_d       = 1'b1;
                state_d      = ctl_pkg::ST_RD_A;
              end else begin
                state_d = ctl_pkg::ST_OUT;
              end
            end
          end
        end
      end
      ctl_pkg::ST_RD_A: state_d = ctl_pkg::ST_RD_B;
      ctl_pkg::ST_RD_B: state_d = ctl_pkg::ST_DIFF;
      ctl_pkg::ST_DIFF: state_d = ctl_pkg::ST_SQR;
      ctl_pkg::ST_SQR:  state_d = ctl_pkg::ST_SUM;
      ctl_pkg::ST_SUM:  state_d = ctl_pkg::ST_ROOT;
      ctl_pkg::ST_ROOT: begin
        if (iter_q == ITER_W'(ROOT_W - 1)) begin
          state_d = ctl_pkg::ST_ACC;
        end
      end
      ctl_pkg::ST_ACC: begin
        // saturating add of the finished distance
        sum_d = sum_wide[LEN_W] ? {LEN_W{1'b1}} : sum_wide[LEN_W-1:0];
        if (need_close_q) begin
          da_d         = prev_q;
          db_d         = '0;
          need_close_d = 1'b0;
          state_d      = ctl_pkg::ST_RD_A;
        end else if (emit_q) begin
          state_d = ctl_pkg::ST_OUT;
        end else begin
          state_d = ctl_pkg::ST_IDLE;
        end
      end
      ctl_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load  = 1'b1;
          prev_d    = '0;
          sum_d     = '0;
          started_d = 1'b0;
          count_d   = '0;
          emit_d    = 1'b0;
          state_d   = ctl_pkg::ST_IDLE;
        end
      end
      default: state_d = ctl_pkg::ST_IDLE;
    endcase
  end

  // output valid holds until the beat is taken
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

@@ src/closed_tour_length_core.sv @@
// top level of the closed tour length block
`timescale 1ns / 1ps
// Sums the Euclidean legs of a closed tour over a table of city positions.
// A position write is handled by the back end in its idle state. A tour city with a
// previous city costs one distance pass: two table reads on the single read
// port, a difference, the squares, their sum, a restoring square root of
// COORD_W + 1 steps at one result bit per cycle, and the add into the sum;
// the operation is popped in the idle state. The closing beat adds a second
// pass for the leg back to city 1, and the result then sits in an output
// register. The front end takes one beat per cycle until the four-entry
// operation queue is full, so bursts are absorbed while the back end works.
// No clearing pass is needed after reset.
module closed_tour_length_core #(
  parameter int unsigned MAX_CITIES = ctl_pkg::MAX_CITIES_DEF,
  parameter int unsigned COORD_BITS = ctl_pkg::COORD_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ctl_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ctl_pkg::out_beat_t out_beat_o
);

  logic         q_full;
  logic         q_push;
  ctl_pkg::op_t q_push_data;
  logic         q_valid;
  logic         q_pop;
  ctl_pkg::op_t q_pop_data;

  // classify incoming beats
  ctl_front #(
    .MAX_CITIES (MAX_CITIES)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_beat_i  (in_beat_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_push_data)
  );

  // decouple front and back
  ctl_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_pop_data)
  );

  // table, distance and sum
  ctl_back #(
    .MAX_CITIES (MAX_CITIES),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_pop_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

@@ sim/tb.sv @@
// self-checking testbench for the closed tour length core
`timescale 1ns / 1ps
module tb;

  localparam int unsigned NUM_CITIES = ctl_pkg::MAX_CITIES_DEF;
  localparam logic [ctl_pkg::LEN_W-1:0] LEN_MAX = '1;
  localparam longint unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 200;

  // tour length predictor with the queue of totals still owed by the block
  class tour_scoreboard;
    logic [ctl_pkg::POS_W-1:0] pos_x_tab [NUM_CITIES];
    logic [ctl_pkg::POS_W-1:0] pos_y_tab [NUM_CITIES];
    int unsigned prev_idx = 0;
    bit in_tour = 1'b0;
    logic [ctl_pkg::COUNT_W-1:0] seen = '0;
    logic [ctl_pkg::LEN_W-1:0] sum = '0;
    ctl_pkg::out_beat_t expected_totals[$];
    int unsigned errors = 0;

    // integer square root rounded down, settled one bit at a time from the top
    function longint unsigned root_floor(longint unsigned v);
      longint unsigned root, trial;
      root = 0;
      for (int i = 16; i >= 0; i--) begin
        trial = root | (64'd1 << i);
        if (trial * trial <= v) root = trial;
      end
      return root;
    endfunction

    function longint unsigned leg(int unsigned a, int unsigned b);
      longint unsigned dx, dy;
      dx = (pos_x_tab[a] >= pos_x_tab[b]) ? pos_x_tab[a] - pos_x_tab[b]
                                          : pos_x_tab[b] - pos_x_tab[a];
      dy = (pos_y_tab[a] >= pos_y_tab[b]) ? pos_y_tab[a] - pos_y_tab[b]
                                          : pos_y_tab[b] - pos_y_tab[a];
      return root_floor(dx * dx + dy * dy);
    endfunction

    // saturating running sum
    function void add_leg(longint unsigned d);
      longint unsigned s;
      s = sum + d;
      sum = (s > LEN_MAX) ? LEN_MAX : s[ctl_pkg::LEN_W-1:0];
    endfunction

    function void note_input(ctl_pkg::in_beat_t b);
      bit ok;
      int unsigned idx;
      ctl_pkg::out_beat_t total;
      ok = (b.city >= 1) && (b.city <= NUM_CITIES);
      idx = ok ? 32'(b.city) - 1 : 0;
      // position write, dropped for a city outside the table
      if (b.command == ctl_pkg::CMD_WRITE) begin
        if (ok) begin
          pos_x_tab[idx] = b.pos_x;
          pos_y_tab[idx] = b.pos_y;
        end
        return;
      end
      // tour city: first one adds nothing, bad ones are skipped
      if (ok) begin
        if (in_tour) add_leg(leg(prev_idx, idx));
        prev_idx = idx;
        in_tour = 1'b1;
        if (seen < NUM_CITIES) seen++;
      end
      if (!b.last) return;
      // close back to city one and start over
      if (in_tour) add_leg(leg(prev_idx, 0));
      total.tour_length = sum;
      total.city_count = seen;
      expected_totals = {expected_totals, total};
      prev_idx = 0;
      sum = '0;
      in_tour = 1'b0;
      seen = '0;
    endfunction

    task report(string what);
      errors++;
      $display("%0t mismatch: %s", $time, what);
    endtask

    task check_result(ctl_pkg::out_beat_t got);
      ctl_pkg::out_beat_t want;
      if (expected_totals.size() == 0) begin
        report($sformatf("total %0d over %0d cities with no tour closed",
                         got.tour_length, got.city_count));
        return;
      end
      want = expected_totals.pop_front();
      if (got.tour_length !== want.tour_length)
        report($sformatf("tour_length %0d, want %0d", got.tour_length, want.tour_length));
      if (got.city_count !== want.city_count)
        report($sformatf("city_count %0d, want %0d", got.city_count, want.city_count));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  ctl_pkg::in_beat_t in_beat;
  logic out_valid;
  logic out_ready;
  ctl_pkg::out_beat_t out_beat;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_request = 0;
  int unsigned live_items = 0;
  int unsigned tour_count = 0;
  longint unsigned cycles = 0;
  bit written [1:NUM_CITIES];
  tour_scoreboard sb;

  closed_tour_length_core DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_beat_i  (in_beat),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_beat_o (out_beat)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("closed_tour_length_core regression: fail");
      $finish;
    end
  end

  // beats seen on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_beat);
      if (in_valid && in_ready) sb.note_input(in_beat);
    end
  end

  // result side: random stalls, or one long hold-off on request
  initial begin
    int unsigned stretch;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        stretch = hold_request;
        hold_request = 0;
        out_ready <= 1'b0;
        repeat (stretch) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // offer one beat after a random gap and hold it until taken
  task automatic send_beat(input ctl_pkg::in_beat_t b);
    int unsigned gap;
    bit bad;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    bad = (b.city == 0) || (b.city > NUM_CITIES);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat <= b;
    do @(posedge clk); while (!in_ready);
    if (!(bad && (b.command == ctl_pkg::CMD_WRITE || !b.last))) live_items++;
    if (b.command == ctl_pkg::CMD_WRITE && !bad) written[b.city] = 1'b1;
  endtask

  task automatic send_write(int unsigned city, logic [ctl_pkg::POS_W-1:0] x,
                            logic [ctl_pkg::POS_W-1:0] y, bit last);
    ctl_pkg::in_beat_t b;
    b.command = ctl_pkg::CMD_WRITE;
    b.city = ctl_pkg::CITY_W'(city);
    b.pos_x = x;
    b.pos_y = y;
    b.last = last;
    send_beat(b);
  endtask

  task automatic send_tour(int unsigned city, bit last);
    ctl_pkg::in_beat_t b;
    b.command = ctl_pkg::CMD_TOUR;
    b.city = ctl_pkg::CITY_W'(city);
    b.pos_x = ctl_pkg::POS_W'($urandom);
    b.pos_y = ctl_pkg::POS_W'($urandom);
    b.last = last;
    send_beat(b);
  endtask

  function automatic logic [ctl_pkg::POS_W-1:0] any_coord();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return ctl_pkg::POS_W'($urandom);
    endcase
  endfunction

  // only cities with a stored position are visited
  function automatic int unsigned written_city();
    int unsigned c;
    do c = $urandom_range(NUM_CITIES, 1); while (!written[c]);
    return c;
  endfunction

  function automatic int unsigned bad_city();
    return $urandom_range(1) ? 0 : $urandom_range(127, NUM_CITIES + 1);
  endfunction

  task automatic short_tour(int unsigned n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 8) send_tour(bad_city(), i == n - 1);
      else send_tour(written_city(), i == n - 1);
    end
  endtask

  // opposite corners back and forth, long enough to saturate sum and count
  task automatic long_tour(int unsigned n);
    send_write(1, '0, '0, 1'($urandom_range(1)));
    send_write(2, '1, '1, 1'($urandom_range(1)));
    for (int i = 0; i < n; i++) send_tour((i % 2) ? 2 : 1, i == n - 1);
  endtask

  task automatic random_stretch(int unsigned target);
    int unsigned start, pick;
    ctl_pkg::in_beat_t junk;
    start = live_items;
    while (live_items - start < target) begin
      pick = $urandom_range(99);
      if (pick < 18) begin
        send_write($urandom_range(NUM_CITIES, 1), any_coord(), any_coord(),
                   1'($urandom_range(1)));
      end else if (pick < 24) begin
        // noise: city outside the table, either command
        junk.command = $urandom_range(1) ? ctl_pkg::CMD_TOUR : ctl_pkg::CMD_WRITE;
        junk.city = ctl_pkg::CITY_W'(bad_city());
        junk.pos_x = ctl_pkg::POS_W'($urandom);
        junk.pos_y = ctl_pkg::POS_W'($urandom);
        junk.last = 1'($urandom_range(1));
        send_beat(junk);
      end else begin
        tour_count++;
        if (tour_count % 80 == 3) long_tour($urandom_range(110, 92));
        else short_tour($urandom_range(8, 1));
      end
    end
  endtask

  initial begin
    sb = new();
    in_valid <= 1'b0;
    in_beat <= '0;
    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner positions for the opening tours
    send_write(1, '0, '0, 1'b1);
    send_write(2, '1, '1, 1'b0);
    send_write(NUM_CITIES, '1, '0, 1'b0);
    // writes outside the table are dropped
    send_write(0, '1, '1, 1'b1);
    send_write(NUM_CITIES + 1, '1, '1, 1'b0);
    send_write(127, '1, '0, 1'b1);
    // empty tour, then a single city closing on itself
    send_tour(0, 1'b1);
    send_tour(1, 1'b1);
    // corner triangle
    send_tour(1, 1'b0);
    send_tour(2, 1'b0);
    send_tour(NUM_CITIES, 1'b1);
    // bad cities inside a tour, closing beat itself bad
    send_tour(2, 1'b0);
    send_tour(100, 1'b0);
    send_tour(NUM_CITIES, 1'b0);
    send_tour(127, 1'b1);
    // tour not starting at city one, repeated city with a zero leg
    send_tour(NUM_CITIES, 1'b1);
    send_tour(2, 1'b0);
    send_tour(2, 1'b1);

    // idle patterns: none, sender gaps, receiver stalls, both
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 77; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 77; end
        default: begin tx_idle_pct = 28; rx_stall_pct = 28; end
      endcase
      random_stretch(210);
    end

    // receiver holds off while closing beats keep coming
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_request = HOLD_CYCLES;
    for (int k = 0; k < 30; k++) send_tour(written_city(), 1'b1);
    in_valid <= 1'b0;

    while (sb.expected_totals.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("closed_tour_length_core regression: pass");
    else $display("closed_tour_length_core regression: fail");
    $finish;
  end

endmodule
